// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert a property on the rising clock edge, disabled while reset is low
`define CHI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assert that an antecedent implies a consequence in the next cycle
`define CHI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/chi_pkg.sv -----
// Types, constants and tables for the CHI hash engine.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package chi_pkg;

    localparam logic [63:0] RC [80] = '{
        64'h9B05688C2B3E6C1F, 64'hDBD99E6FF3C90BDC, 64'h4DBC64712A5BB168, 64'h767E27C3CF76C8E7,
        64'h21EE9AC5EF4C823A, 64'hB36CCFC1204A9BD8, 64'h754C8A7FB36BD941, 64'hCF20868F04A825E9,
        64'hABB379E0A8838BB0, 64'h12D8B70A5959E391, 64'hB59168FA9F69E181, 64'h15C7D4918739F18F,
        64'h4B547673EA8D68E0, 64'h3CED7326FCD0EF81, 64'h09F1D77309998460, 64'h1AF3937415E91F32,
        64'h1F83D9ABFB41BD6B, 64'h23C4654C2A217583, 64'h2842012131573F2A, 64'hA59916ACA3991FCA,
        64'hEC1B7C06FD19D256, 64'h1EC785BCDC8BAF26, 64'h69CA4E0FF2E6BDD8, 64'hCA2575EE6C950D0E,
        64'h5BCF66D2FB3D99F6, 64'h9D6D08C7BBCA18F3, 64'hEEF64039F2175E83, 64'h00ED5AEBAA2AB6E0,
        64'h5040712FC29AD308, 64'h6DAFE433438D2C43, 64'hBD7FAA3F06C71F15, 64'h03B5AA8CE9B6A4DD,
        64'h5BE0CD19137E2179, 64'h867F5E3B72221265, 64'h43B6CBE0D67F4A20, 64'hDB99D767CB0E4933,
        64'hDC450DBC469248BD, 64'hFE1E5E4876100D6F, 64'hB799D29EA1733137, 64'h16EA7ABCF92053C4,
        64'hBE3ECE968DBA92AC, 64'h18538F84D82C318B, 64'h38D79F4E9C8A18C0, 64'hA8BBC28F1271F1F7,
        64'h2796E71067D2C8CC, 64'hDE1BF2334EDB3FF6, 64'hB094D782A857F9C1, 64'h639B484B0C1DAED1,
        64'hCBBB9D5DC1059ED8, 64'hE7730EAFF25E24A3, 64'hF367F2FC266A0373, 64'hFE7A4D34486D08AE,
        64'hD41670A136851F32, 64'h663914B66B4B3C23, 64'h1B9E3D7740A60887, 64'h63C11D86D446CB1C,
        64'hD167D2469049D628, 64'hDDDBB606B9A49E38, 64'h557F1C8BEE68A7F7, 64'hF99DC58B50F924BD,
        64'h205ACC9F653512A5, 64'h67C66344E4BAB193, 64'h18026E467960D0C8, 64'hA2F5D84DAECA8980,
        64'h629A292A367CD507, 64'h98E67012D90CBB6D, 64'hEED758D1D18C7E35, 64'h031C02E4437DC71E,
        64'h79B63D6482198EB7, 64'h936A9D7E8C9E4B33, 64'hB30CA682C3E6C65D, 64'hCC442382BA4262FA,
        64'h51179BA5A1D37FF6, 64'h7202BDE7A98EEA51, 64'h2B9F65D1DF9C610F, 64'hF56B742B0AF1CE83,
        64'hF9989D199B75848B, 64'hD142F19D8B46D578, 64'h7A7580514D75EA33, 64'hB74F9690808E704D
    };

    localparam logic [63:0] IV_ODD [9] = '{
        64'hA54FF53A5F1D36F1, 64'hCEA7E61FC37A20D5, 64'h4A77FE7B78415DFC, 64'h8E34A6FE8E2DF92A,
        64'h4E5B408C9C97D4D8, 64'h24A05EEE29922401, 64'h5A8176CFFC7C2224, 64'hC3EDEBDA29BEC4C8,
        64'h8A074C0F4D999610
    };

    localparam logic [63:0] IV_EVEN [9] = '{
        64'h510E527FADE682D1, 64'hDE49E330E42B4CBB, 64'h29BA5A455316E0C6, 64'h5507CD18E9E51E69,
        64'h4F9B11C81009A030, 64'hE3D3775F155385C6, 64'h489221632788FB30, 64'h41921DB8FEEB38C2,
        64'h9AF94A7C48BBD5B6
    };

    localparam logic [1:0] MODE_224 = 2'd0;
    localparam logic [1:0] MODE_256 = 2'd1;
    localparam logic [1:0] MODE_384 = 2'd2;
    localparam logic [1:0] MODE_512 = 2'd3;

    function automatic logic [63:0] iv_word(input logic [1:0] mode, input int unsigned j);
        logic [63:0] w;
        w = mode[0] ? IV_EVEN[j] : IV_ODD[j];
        if (!mode[1] && j >= 6) begin
            w = 64'd0;
        end
        return w;
    endfunction

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PAD,
        ST_CHECK,
        ST_LEN,
        ST_ZLEN,
        ST_CINIT,
        ST_ROUND,
        ST_FFWD,
        ST_EMIT,
        ST_ERR
    } state_t;

    typedef enum logic [1:0] {
        RET_ABSORB,
        RET_EXTRA,
        RET_FINAL
    } ret_t;

    typedef enum logic [2:0] {
        W_HOLD,
        W_ABSORB,
        W_PAD,
        W_LEN,
        W_ZERO_LEN,
        W_SHIFT
    } w_op_t;

    typedef enum logic [1:0] {
        LEN_NONE,
        LEN_BLOCK,
        LEN_TAIL
    } len_op_t;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_DIGEST,
        OUT_ERR
    } out_op_t;

    typedef struct packed {
        logic    in_load;
        w_op_t   w_op;
        len_op_t len_op;
        logic    g_init;
        logic    final_rot;
        logic    ffwd;
        logic    load_iv;
        out_op_t out_op;
    } cmd_t;

    typedef struct packed {
        logic partial;
        logic last;
        logic block_full_next;
        logic pad_extra;
        logic len_err;
        logic round_last;
        logic out_free;
        logic emit_last;
    } status_t;

endpackage

// ----- rtl/chi_datapath.sv -----
// Datapath of the CHI hash engine: message window and expansion, round unit,
// chaining value, length counter, input and output registers. Uses chi_pkg.
`timescale 1ns / 1ps

module chi_datapath import chi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic [63:0] in_data,
    input  logic [6:0]  in_bits,
    input  logic        in_last,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [63:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tuser
);

    function automatic logic [63:0] rr64(input logic [63:0] x, input int unsigned r);
        return (x >> r) | (x << (64 - r));
    endfunction

    function automatic logic [31:0] rr32(input logic [31:0] x, input int unsigned r);
        return (x >> r) | (x << (32 - r));
    endfunction

    function automatic logic [63:0] rh(input logic [63:0] x, input int unsigned a,
                                       input int unsigned b);
        return {rr32(x[63:32], a), rr32(x[31:0], b)};
    endfunction

    function automatic logic [63:0] brev(input logic [63:0] x);
        logic [63:0] y;
        for (int k = 0; k < 8; k++) begin
            y[8*k +: 8] = x[8*(7-k) +: 8];
        end
        return y;
    endfunction

    logic [1:0]  mode_reg, mode_next;
    logic [63:0] cv_reg [9];
    logic [63:0] cv_next [9];
    logic [63:0] w_reg [16];
    logic [63:0] w_next [16];
    logic [63:0] g_reg [9];
    logic [63:0] g_next [9];
    logic [63:0] len_lo_reg, len_lo_next;
    logic [63:0] len_hi_reg, len_hi_next;
    logic        len_err_reg, len_err_next;
    logic [4:0]  fill_reg, fill_next;
    logic [5:0]  round_reg, round_next;
    logic [1:0]  mod3_reg, mod3_next;
    logic [2:0]  idx_reg, idx_next;
    logic [63:0] in_data_reg, in_data_next;
    logic [6:0]  in_b_reg, in_b_next;
    logic        in_last_reg, in_last_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;
    logic        out_err_reg, out_err_next;

    logic        big;
    logic [4:0]  nb;
    logic        iv_load;
    logic [1:0]  iv_mode;
    logic [63:0] padded;
    logic        partial;
    logic [10:0] add_bits;
    logic [64:0] len_sum;
    logic [63:0] new0, new1;
    logic [63:0] na, nd, ng;
    logic [63:0] digest;
    logic        emit_last;
    logic        out_free;

    assign big      = mode_reg[1];
    assign nb       = big ? 5'd16 : 5'd8;
    assign iv_load  = cfg_wr_en || cmd.load_iv;
    assign iv_mode  = cfg_wr_en ? cfg_wr_data : mode_reg;
    assign partial  = (in_b_reg != 7'd64);
    assign out_free = !out_valid_reg || m_tready;

    assign padded = partial ? ((in_data_reg & ~({64{1'b1}} >> in_b_reg))
                               | (64'h8000_0000_0000_0000 >> in_b_reg))
                            : 64'h8000_0000_0000_0000;

    // message expansion, two words per round
    always_comb begin
        if (big) begin
            new0 = w_reg[0] ^ w_reg[9]
                 ^ (rr64(w_reg[1], 36) ^ rr64(w_reg[1], 18) ^ (w_reg[1] >> 1))
                 ^ (rr64(w_reg[14], 60) ^ rr64(w_reg[14], 30) ^ (w_reg[14] >> 3));
            new1 = w_reg[1] ^ w_reg[10]
                 ^ (rr64(w_reg[2], 36) ^ rr64(w_reg[2], 18) ^ (w_reg[2] >> 1))
                 ^ (rr64(w_reg[15], 60) ^ rr64(w_reg[15], 30) ^ (w_reg[15] >> 3));
        end else begin
            new0 = w_reg[0]
                 ^ (rr64(w_reg[1], 36) ^ rr64(w_reg[1], 18) ^ (w_reg[1] >> 1))
                 ^ (rr64(w_reg[6], 59) ^ rr64(w_reg[6], 37) ^ (w_reg[6] >> 10));
            new1 = w_reg[1]
                 ^ (rr64(w_reg[2], 36) ^ rr64(w_reg[2], 18) ^ (w_reg[2] >> 1))
                 ^ (rr64(w_reg[7], 59) ^ rr64(w_reg[7], 37) ^ (w_reg[7] >> 10));
        end
    end

    // one round
    always_comb begin : round_unit
        logic [63:0] v0, v1, r, s, t, u, m0, m1, m2, x, y, z, yy, zz;
        v0 = w_reg[0] ^ RC[{round_reg, 1'b0}];
        v1 = w_reg[1] ^ RC[{round_reg, 1'b1}];
        if (big) begin
            r = rr64(g_reg[1], 11) ^ rr64(g_reg[3], 8) ^ rr64(g_reg[6], 13) ^ v0;
            s = g_reg[0] ^ rr64(g_reg[3], 21) ^ rr64(g_reg[6], 29) ^ v1;
            t = rr64(g_reg[0], 11) ^ rr64(g_reg[3], 38) ^ g_reg[7]
              ^ rr64(v0, 5) ^ rr64(v0, 6) ^ rr64(v0, 43);
            u = rr64(g_reg[0], 26) ^ rr64(g_reg[4], 40) ^ rr64(g_reg[6], 50)
              ^ rr64(v1, 20) ^ rr64(v1, 30) ^ rr64(v1, 49);
        end else begin
            r = rh(g_reg[1], 8, 8) ^ rh(rr64(g_reg[3], 32), 5, 1) ^ v0;
            s = g_reg[0] ^ rh(rr64(g_reg[3], 32), 18, 17) ^ v1;
            t = rh(rr64(g_reg[0], 32), 7, 26) ^ rh(g_reg[3], 14, 22)
              ^ rh(v0, 21, 21) ^ rh(v0, 26, 26) ^ rh(v0, 30, 30);
            u = rh(g_reg[0], 17, 12) ^ rh(rr64(g_reg[4], 32), 2, 23)
              ^ rh(v1, 14, 14) ^ rh(v1, 24, 24) ^ rh(v1, 31, 31);
        end
        m0 = (r & ~s & t & u) | (~s & ~t & ~u) | (~r & ~t & u) | (~r & s & t) | (r & ~t & ~u);
        m1 = (r & s & t & ~u) | (r & ~s & ~t & ~u) | (~r & ~s & t) | (s & ~t & u) | (~r & u);
        m2 = (~r & ~s & t & u) | (~r & s & t & ~u) | (s & ~t & u) | (r & ~t & ~u)
           | (r & s & u) | (r & ~s & ~u);
        unique case (mod3_reg)
            2'd1: begin
                x = m1; y = m2; z = m0;
            end
            2'd2: begin
                x = m2; y = m0; z = m1;
            end
            default: begin
                x = m0; y = m1; z = m2;
            end
        endcase
        yy = big ? brev(rr64(y, 31)) : brev(rh(y, 5, 5));
        zz = rr64(z, 32);
        na = rr64(x + yy, 16) ^ (big ? g_reg[8] : g_reg[5]);
        nd = rr64(yy + zz, 48) ^ g_reg[2];
        ng = (zz + {x[62:0], 1'b0}) ^ g_reg[5];
    end

    // digest word selection
    always_comb begin
        if (big) begin
            digest    = cv_reg[idx_reg];
            emit_last = (mode_reg == MODE_384) ? (idx_reg == 3'd5) : (idx_reg == 3'd7);
        end else begin
            unique case (idx_reg[1:0])
                2'd0: digest = cv_reg[0];
                2'd1: digest = cv_reg[1];
                2'd2: digest = cv_reg[3];
                default: digest = cv_reg[4];
            endcase
            if (mode_reg == MODE_224 && idx_reg[1:0] == 2'd3) begin
                digest = digest & 64'hFFFF_FFFF_0000_0000;
            end
            emit_last = (idx_reg[1:0] == 2'd3);
        end
    end

    always_comb begin
        unique case (cmd.len_op)
            LEN_BLOCK: add_bits = big ? 11'd1024 : 11'd512;
            LEN_TAIL:  add_bits = {fill_reg, 6'd0} + (partial ? {4'd0, in_b_reg} : 11'd0);
            default:   add_bits = 11'd0;
        endcase
        len_sum = {1'b0, len_lo_reg} + {54'd0, add_bits};
    end

    always_comb begin
        mode_next      = cfg_wr_en ? cfg_wr_data : mode_reg;
        len_lo_next    = len_lo_reg;
        len_hi_next    = len_hi_reg;
        len_err_next   = len_err_reg;
        fill_next      = fill_reg;
        round_next     = round_reg;
        mod3_next      = mod3_reg;
        idx_next       = idx_reg;
        in_data_next   = in_data_reg;
        in_b_next      = in_b_reg;
        in_last_next   = in_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        cv_next        = cv_reg;
        w_next         = w_reg;
        g_next         = g_reg;

        if (cmd.in_load) begin
            in_data_next = in_data;
            in_b_next    = (in_bits > 7'd64) ? 7'd64 : in_bits;
            in_last_next = in_last;
        end

        unique case (cmd.w_op)
            W_ABSORB: begin
                w_next[fill_reg[3:0]] = in_data_reg;
                fill_next = fill_reg + 5'd1;
            end
            W_PAD: begin
                for (int j = 0; j < 16; j++) begin
                    if (5'(j) == fill_reg) begin
                        w_next[j] = padded;
                    end else if (5'(j) > fill_reg && 5'(j) < nb) begin
                        w_next[j] = 64'd0;
                    end
                end
            end
            W_LEN, W_ZERO_LEN: begin
                if (cmd.w_op == W_ZERO_LEN) begin
                    for (int j = 0; j < 16; j++) begin
                        w_next[j] = 64'd0;
                    end
                end
                if (big) begin
                    w_next[14] = len_hi_reg;
                    w_next[15] = len_lo_reg;
                end else begin
                    w_next[7] = len_lo_reg;
                end
            end
            W_SHIFT: begin
                for (int j = 0; j < 14; j++) begin
                    w_next[j] = w_reg[j+2];
                end
                if (big) begin
                    w_next[14] = new0;
                    w_next[15] = new1;
                end else begin
                    w_next[6] = new0;
                    w_next[7] = new1;
                end
                round_next = round_reg + 6'd1;
                mod3_next  = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
                g_next[0] = na;
                g_next[1] = g_reg[0];
                g_next[2] = g_reg[1];
                g_next[3] = nd;
                g_next[4] = g_reg[3];
                g_next[5] = g_reg[4];
                if (big) begin
                    g_next[6] = ng;
                    g_next[7] = g_reg[6];
                    g_next[8] = g_reg[7];
                end
            end
            default: begin
            end
        endcase

        if (cmd.len_op != LEN_NONE) begin
            len_lo_next = len_sum[63:0];
            if (len_sum[64]) begin
                if (!big) begin
                    len_err_next = 1'b1;
                end else begin
                    len_hi_next = len_hi_reg + 64'd1;
                    if (len_hi_reg == {64{1'b1}}) begin
                        len_err_next = 1'b1;
                    end
                end
            end
            if (cmd.len_op == LEN_BLOCK) begin
                fill_next = 5'd0;
            end
        end

        if (cmd.g_init) begin
            round_next = 6'd0;
            mod3_next  = 2'd0;
            for (int j = 0; j < 9; j++) begin
                if (j < 6 || big) begin
                    g_next[j] = cmd.final_rot ? rr64(cv_reg[j], 1) : cv_reg[j];
                end else begin
                    g_next[j] = 64'd0;
                end
            end
        end

        if (cmd.ffwd) begin
            for (int j = 0; j < 9; j++) begin
                if (j < 6 || big) begin
                    cv_next[j] = rr64(cv_reg[j], 1) ^ g_reg[j];
                end
            end
        end

        unique case (cmd.out_op)
            OUT_DIGEST: begin
                out_valid_next = 1'b1;
                out_data_next  = digest;
                out_last_next  = emit_last;
                out_err_next   = 1'b0;
                idx_next       = emit_last ? 3'd0 : idx_reg + 3'd1;
            end
            OUT_ERR: begin
                out_valid_next = 1'b1;
                out_data_next  = 64'd0;
                out_last_next  = in_last_reg;
                out_err_next   = 1'b1;
            end
            default: begin
            end
        endcase

        if (iv_load) begin
            for (int j = 0; j < 9; j++) begin
                cv_next[j] = iv_word(iv_mode, j);
            end
            len_lo_next  = 64'd0;
            len_hi_next  = 64'd0;
            len_err_next = 1'b0;
            fill_next    = 5'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_256;
            for (int j = 0; j < 9; j++) begin
                cv_reg[j] <= iv_word(MODE_256, j);
            end
            len_lo_reg    <= 64'd0;
            len_hi_reg    <= 64'd0;
            len_err_reg   <= 1'b0;
            fill_reg      <= 5'd0;
            round_reg     <= 6'd0;
            mod3_reg      <= 2'd0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            cv_reg        <= cv_next;
            len_lo_reg    <= len_lo_next;
            len_hi_reg    <= len_hi_next;
            len_err_reg   <= len_err_next;
            fill_reg      <= fill_next;
            round_reg     <= round_next;
            mod3_reg      <= mod3_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg        <= w_next;
        g_reg        <= g_next;
        in_data_reg  <= in_data_next;
        in_b_reg     <= in_b_next;
        in_last_reg  <= in_last_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign status.partial         = partial;
    assign status.last            = in_last_reg;
    assign status.block_full_next = (fill_reg == nb - 5'd1);
    assign status.pad_extra       = (fill_reg >= nb - (big ? 5'd2 : 5'd1));
    assign status.len_err         = len_err_reg;
    assign status.round_last      = (round_reg == (big ? 6'd39 : 6'd19));
    assign status.out_free        = out_free;
    assign status.emit_last       = emit_last;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

endmodule

// ----- rtl/chi_ctrl.sv -----
// Controller of the CHI hash engine: sequences absorb, padding, compression
// and digest output. Uses chi_pkg.
`timescale 1ns / 1ps

module chi_ctrl import chi_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= RET_ABSORB;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.partial) begin
                    state_next = status.last ? ST_PAD : ST_ERR;
                end else if (status.block_full_next) begin
                    ret_next   = RET_ABSORB;
                    state_next = ST_CINIT;
                end else begin
                    state_next = status.last ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD: state_next = ST_CHECK;
            ST_CHECK: begin
                if (status.len_err) begin
                    state_next = ST_ERR;
                end else if (status.pad_extra) begin
                    ret_next   = RET_EXTRA;
                    state_next = ST_CINIT;
                end else begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN, ST_ZLEN: begin
                ret_next   = RET_FINAL;
                state_next = ST_CINIT;
            end
            ST_CINIT: state_next = ST_ROUND;
            ST_ROUND: begin
                if (status.round_last) begin
                    state_next = ST_FFWD;
                end
            end
            ST_FFWD: begin
                unique case (ret_reg)
                    RET_ABSORB: state_next = status.last ? ST_PAD : ST_IDLE;
                    RET_EXTRA:  state_next = ST_ZLEN;
                    default:    state_next = ST_EMIT;
                endcase
            end
            ST_EMIT: begin
                if (status.out_free && status.emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = (state_reg == ST_IDLE);
        cmd.in_load   = 1'b0;
        cmd.w_op      = W_HOLD;
        cmd.len_op    = LEN_NONE;
        cmd.g_init    = 1'b0;
        cmd.final_rot = 1'b0;
        cmd.ffwd      = 1'b0;
        cmd.load_iv   = 1'b0;
        cmd.out_op    = OUT_NONE;
        unique case (state_reg)
            ST_IDLE:   cmd.in_load = s_tvalid;
            ST_DECODE: begin
                if (!status.partial) begin
                    cmd.w_op = W_ABSORB;
                end
            end
            ST_PAD:    cmd.len_op = LEN_TAIL;
            ST_CHECK: begin
                if (status.len_err) begin
                    cmd.load_iv = 1'b1;
                end else begin
                    cmd.w_op = W_PAD;
                end
            end
            ST_LEN:    cmd.w_op = W_LEN;
            ST_ZLEN:   cmd.w_op = W_ZERO_LEN;
            ST_CINIT: begin
                cmd.g_init    = 1'b1;
                cmd.final_rot = (ret_reg == RET_FINAL);
            end
            ST_ROUND:  cmd.w_op = W_SHIFT;
            ST_FFWD: begin
                cmd.ffwd = 1'b1;
                if (ret_reg == RET_ABSORB) begin
                    cmd.len_op = LEN_BLOCK;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_op  = OUT_DIGEST;
                    cmd.load_iv = status.emit_last;
                end
            end
            ST_ERR: begin
                if (status.out_free) begin
                    cmd.out_op = OUT_ERR;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/chi_hash_engine_unit.sv -----
// CHI hash engine top level: stream ports and mode register, wires the
// controller to the datapath. Uses chi_pkg, chi_ctrl and chi_datapath.
`timescale 1ns / 1ps

// Feed 64-bit big-endian message words; only the word with s_tlast may carry
// fewer than 64 valid bits. A word that does not complete a block passes
// through the decode state before s_tready returns. A word that completes a
// block also runs the compression (initial load, one round per cycle in the
// round unit, then feed-forward), and s_tready stays low until it is done.
// The last word adds padding, an extra block when the length does not fit,
// and the final block, then the digest leaves on the master side at one word
// per cycle while m_tready is high (4, 6 or 8 words). A partial word without
// s_tlast, or a length overflow, gives one word with tuser set instead.
// Write the mode only while the engine is idle; it restarts the message.

module chi_hash_engine_unit import chi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // data_word[63:0], bit_count[70:64], zero[71]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // digest_word[63:0]
    output logic        m_tlast,
    output logic        m_tuser    // error
);

    cmd_t    cmd;
    status_t status;

    chi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    chi_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (s_tdata[63:0]),
        .in_bits     (s_tdata[70:64]),
        .in_last     (s_tlast),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

// ----- rtl/chi_checker.sv -----
// Port-level checker for the CHI hash engine, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chi_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_wr_en,
    input logic [1:0]  cfg_wr_data,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [71:0] s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    `CHI_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result changed")
    `CHI_ASSERT(a_err_zero, aclk, aresetn, (m_tvalid && m_tuser) |-> (m_tdata == 64'd0), "error transfer carries data")
    `CHI_ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken twice in a row")

endmodule

bind chi_hash_engine_unit chi_checker u_chk (.*);

// ----- tb/tb_chi_hash_engine_unit.sv -----
// Self-checking testbench for chi_hash_engine_unit: random messages in all four
// digest modes, with a CHI digest predictor held in a small scoreboard class.
// Depends on chi_pkg (modes, initial values, round constants) and the RTL.
`timescale 1ns / 1ps

module tb_chi_hash_engine_unit;
    import chi_pkg::*;

    typedef struct packed {
        logic [63:0] word;
        logic        last;
        logic        err;
    } digest_t;

    class digest_scoreboard;
        logic [1:0]  mode;
        logic [63:0] cv [9];
        logic [63:0] win [16];
        logic [63:0] len_lo;
        logic [63:0] len_hi;
        int unsigned fill;
        bit          len_err;
        digest_t     pending_q [$];
        int          errors;

        function logic [63:0] rot64(logic [63:0] x, int unsigned r);
            r = r % 64;
            if (r == 0) return x;
            return (x >> r) | (x << (64 - r));
        endfunction

        function logic [31:0] rot32(logic [31:0] x, int unsigned r);
            r = r % 32;
            if (r == 0) return x;
            return (x >> r) | (x << (32 - r));
        endfunction

        function logic [63:0] roth(logic [63:0] x, int unsigned rh, int unsigned rl);
            return {rot32(x[63:32], rh), rot32(x[31:0], rl)};
        endfunction

        function logic [63:0] byte_swap(logic [63:0] x);
            return {<<8{x}};
        endfunction

        function bit large_mode();
            return mode >= MODE_384;
        endfunction

        function int unsigned blk_words();
            return large_mode() ? 16 : 8;
        endfunction

        function void restart();
            int unsigned n;
            n = large_mode() ? 9 : 6;
            for (int unsigned j = 0; j < 9; j++) begin
                cv[j] = 64'd0;
                if (j < n) cv[j] = mode[0] ? IV_EVEN[j] : IV_ODD[j];
            end
            len_lo = 0;
            len_hi = 0;
            fill = 0;
            len_err = 0;
        endfunction

        function void set_mode(logic [1:0] m);
            mode = m;
            restart();
        endfunction

        function void compress(bit fin);
            logic [63:0] w [80];
            logic [63:0] g [9];
            logic [63:0] m [3];
            logic [63:0] v0, v1, r, s, t, u, x, y, z, yy, zz, na, nd, ng;
            bit big;
            int unsigned n, nb, rounds;
            big = large_mode();
            n = big ? 9 : 6;
            nb = blk_words();
            rounds = big ? 40 : 20;
            for (int unsigned j = 0; j < 9; j++) begin
                g[j] = 0;
                if (j < n) g[j] = fin ? rot64(cv[j], 1) : cv[j];
            end
            for (int unsigned j = 0; j < nb; j++) w[j] = win[j];
            for (int unsigned j = nb; j < 2 * rounds; j++) begin
                if (big)
                    w[j] = w[j-16] ^ w[j-7]
                        ^ (rot64(w[j-15], 36) ^ rot64(w[j-15], 18) ^ (w[j-15] >> 1))
                        ^ (rot64(w[j-2], 60) ^ rot64(w[j-2], 30) ^ (w[j-2] >> 3));
                else
                    w[j] = w[j-8]
                        ^ (rot64(w[j-7], 36) ^ rot64(w[j-7], 18) ^ (w[j-7] >> 1))
                        ^ (rot64(w[j-2], 59) ^ rot64(w[j-2], 37) ^ (w[j-2] >> 10));
            end
            for (int unsigned i = 0; i < rounds; i++) begin
                v0 = w[2*i] ^ RC[2*i];
                v1 = w[2*i+1] ^ RC[2*i+1];
                if (big) begin
                    r = rot64(g[1], 11) ^ rot64(g[3], 8) ^ rot64(g[6], 13) ^ v0;
                    s = g[0] ^ rot64(g[3], 21) ^ rot64(g[6], 29) ^ v1;
                    t = rot64(g[0], 11) ^ rot64(g[3], 38) ^ g[7]
                        ^ rot64(v0, 5) ^ rot64(v0, 6) ^ rot64(v0, 43);
                    u = rot64(g[0], 26) ^ rot64(g[4], 40) ^ rot64(g[6], 50)
                        ^ rot64(v1, 20) ^ rot64(v1, 30) ^ rot64(v1, 49);
                end else begin
                    r = roth(g[1], 8, 8) ^ roth(rot64(g[3], 32), 5, 1) ^ v0;
                    s = g[0] ^ roth(rot64(g[3], 32), 18, 17) ^ v1;
                    t = roth(rot64(g[0], 32), 7, 26) ^ roth(g[3], 14, 22)
                        ^ roth(v0, 21, 21) ^ roth(v0, 26, 26) ^ roth(v0, 30, 30);
                    u = roth(g[0], 17, 12) ^ roth(rot64(g[4], 32), 2, 23)
                        ^ roth(v1, 14, 14) ^ roth(v1, 24, 24) ^ roth(v1, 31, 31);
                end
                m[0] = (r & ~s & t & u) | (~s & ~t & ~u) | (~r & ~t & u) | (~r & s & t)
                     | (r & ~t & ~u);
                m[1] = (r & s & t & ~u) | (r & ~s & ~t & ~u) | (~r & ~s & t) | (s & ~t & u)
                     | (~r & u);
                m[2] = (~r & ~s & t & u) | (~r & s & t & ~u) | (s & ~t & u) | (r & ~t & ~u)
                     | (r & s & u) | (r & ~s & ~u);
                x = m[i % 3];
                y = m[(i + 1) % 3];
                z = m[(i + 2) % 3];
                zz = rot64(z, 32);
                if (big) begin
                    yy = byte_swap(rot64(y, 31));
                    na = rot64(x + yy, 16) ^ g[8];
                    nd = rot64(yy + zz, 48) ^ g[2];
                    ng = (zz + (x << 1)) ^ g[5];
                    g[8] = g[7];
                    g[7] = g[6];
                    g[6] = ng;
                end else begin
                    yy = byte_swap(roth(y, 5, 5));
                    na = rot64(x + yy, 16) ^ g[5];
                    nd = rot64(yy + zz, 48) ^ g[2];
                end
                g[5] = g[4];
                g[4] = g[3];
                g[3] = nd;
                g[2] = g[1];
                g[1] = g[0];
                g[0] = na;
            end
            for (int unsigned j = 0; j < n; j++) cv[j] = rot64(cv[j], 1) ^ g[j];
        endfunction

        function void add_len(logic [63:0] bits);
            logic [63:0] old;
            old = len_lo;
            len_lo = len_lo + bits;
            if (len_lo < old) begin
                if (!large_mode()) begin
                    len_err = 1;
                end else begin
                    len_hi = len_hi + 1;
                    if (len_hi == 0) len_err = 1;
                end
            end
        endfunction

        function void absorb(logic [63:0] word);
            win[fill % 16] = word;
            fill++;
            if (fill >= blk_words()) begin
                compress(0);
                add_len(blk_words() * 64);
                fill = 0;
            end
        endfunction

        function void push(logic [63:0] word, logic l, logic e);
            digest_t d;
            d.word = word;
            d.last = l;
            d.err = e;
            pending_q.push_back(d);
        endfunction

        function void note_transfer(logic [63:0] data, logic [6:0] cnt, logic last);
            int unsigned b, nb, lw, p, cnt_out;
            logic [63:0] padded, bits, v;
            int unsigned small_order [4];
            small_order = '{0, 1, 3, 4};
            b = (cnt > 64) ? 64 : cnt;
            if (!last) begin
                if (b != 64) push(64'd0, 1'b0, 1'b1);
                else absorb(data);
                return;
            end
            if (b == 64) begin
                absorb(data);
                padded = 64'h8000000000000000;
                bits = fill * 64;
            end else begin
                padded = (b == 0) ? 64'd0 : (data & ({64{1'b1}} << (64 - b)));
                padded = padded | (64'd1 << (63 - b));
                bits = fill * 64 + b;
            end
            add_len(bits);
            if (len_err) begin
                restart();
                push(64'd0, 1'b1, 1'b1);
                return;
            end
            nb = blk_words();
            lw = large_mode() ? 2 : 1;
            p = fill;
            win[p] = padded;
            for (int unsigned j = p + 1; j < nb; j++) win[j] = 0;
            if (p >= nb - lw) begin
                compress(0);
                for (int unsigned j = 0; j < nb; j++) win[j] = 0;
            end
            if (large_mode()) win[nb-2] = len_hi;
            win[nb-1] = len_lo;
            compress(1);
            if (!large_mode()) begin
                for (int unsigned j = 0; j < 4; j++) begin
                    v = cv[small_order[j]];
                    if (mode == MODE_224 && j == 3) v[31:0] = 32'd0;
                    push(v, j == 3, 1'b0);
                end
            end else begin
                cnt_out = (mode == MODE_384) ? 6 : 8;
                for (int unsigned j = 0; j < cnt_out; j++) push(cv[j], j == cnt_out - 1, 1'b0);
            end
            restart();
        endfunction

        function void check_result(logic [63:0] word, logic l, logic e);
            digest_t d;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result word %h last %b err %b", $time, word, l, e);
                errors++;
                return;
            end
            d = pending_q.pop_front();
            if (d.word !== word) begin
                $display("%0t: digest word expected %h actual %h", $time, d.word, word);
                errors++;
            end
            if (d.last !== l) begin
                $display("%0t: tlast expected %b actual %b", $time, d.last, l);
                errors++;
            end
            if (d.err !== e) begin
                $display("%0t: tuser expected %b actual %b", $time, d.err, e);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 120;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    digest_scoreboard sb;
    int  items_sent;
    bit  no_gaps;

    chi_hash_engine_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [63:0] pick_word();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 64'd0;
        if (roll == 1) return {64{1'b1}};
        return {$urandom, $urandom};
    endfunction

    // offer one word and hold it until the transfer completes
    task automatic send_word(logic [63:0] data, logic [6:0] cnt, logic last);
        int unsigned gap;
        bit hs;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, cnt, data};
        s_tlast  <= last;
        do begin
            @(negedge aclk);
            hs = s_tready;
            @(posedge aclk);
        end while (!hs);
        sb.note_transfer(data, cnt, last);
        items_sent++;
    endtask

    task automatic drain_and_idle();
        @(posedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(logic [1:0] m);
        drain_and_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_mode(m);
    endtask

    task automatic send_message(int unsigned nwords, logic [6:0] last_cnt, bit noise);
        for (int unsigned k = 0; k < nwords; k++) begin
            if (noise && $urandom_range(0, 5) == 0)
                send_word(pick_word(), 7'($urandom_range(0, 63)), 1'b0);
            send_word(pick_word(), 7'd64, 1'b0);
        end
        send_word(pick_word(), last_cnt, 1'b1);
    endtask

    task automatic random_message();
        int unsigned nwords;
        int unsigned roll;
        logic [6:0] cnt;
        nwords = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 18) : $urandom_range(0, 5);
        roll = $urandom_range(0, 99);
        if (roll < 25) cnt = 7'd64;
        else if (roll < 35) cnt = 7'($urandom_range(65, 127));
        else cnt = 7'($urandom_range(0, 63));
        send_message(nwords, cnt, $urandom_range(0, 4) == 0);
    endtask

    // receiver: random back-pressure, always-ready windows and one long hold-off
    initial begin
        int unsigned cyc;
        int unsigned stall;
        int unsigned hold;
        cyc = 0;
        stall = 0;
        hold = 0;
        m_tready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
            @(posedge aclk);
            cyc++;
            if (cyc == 4000) hold = 1500;
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if ((cyc / 2500) % 3 == 2) begin
                m_tready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                stall = pick_gap();
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned idle;
        idle = 0;
        forever begin
            @(negedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
            if (idle >= WATCHDOG_LIMIT) begin
                $display("chi_hash_engine_unit regression: fail");
                $finish;
            end
        end
    end

    initial begin
        logic [1:0] phase_modes [6];
        int unsigned phase_start;
        phase_modes = '{MODE_224, MODE_384, MODE_512, MODE_256, MODE_512, MODE_224};
        sb = new();
        sb.errors = 0;
        sb.set_mode(MODE_256);
        items_sent = 0;
        no_gaps = 0;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 2'd0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset mode first
        send_word(64'd0, 7'd0, 1'b1);
        send_word({64{1'b1}}, 7'd64, 1'b1);
        send_word({64{1'b1}}, 7'd127, 1'b1);
        send_word({64{1'b1}}, 7'd63, 1'b1);
        send_word(64'h0123456789ABCDEF, 7'd5, 1'b0);
        send_message(7, 7'd10, 0);
        send_message(6, 7'd64, 0);
        write_mode(MODE_512);
        send_message(0, 7'd1, 0);
        send_message(14, 7'd64, 0);

        for (int ph = 0; ph < 6; ph++) begin
            write_mode(phase_modes[ph]);
            no_gaps = (ph == 3);
            phase_start = items_sent;
            while (items_sent - phase_start < 34) random_message();
        end
        write_mode(2'($urandom_range(0, 3)));
        no_gaps = 0;
        phase_start = items_sent;
        while (items_sent - phase_start < 20) random_message();

        drain_and_idle();
        if (sb.errors == 0) begin
            $display("chi_hash_engine_unit regression: pass");
        end else begin
            $display("chi_hash_engine_unit regression: fail");
        end
        $finish;
    end
endmodule
